FILE: rtl/core/assert_macros.svh
// Assertion macros for the RTL; fskdd_queue uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) \
    else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, prop)
`endif
`endif

FILE: rtl/core/fskdd_pkg.sv
package fskdd_pkg;

  localparam int unsigned DiscTaps = 5;
  localparam int unsigned LpfTaps = 17;
  localparam int unsigned QueueDepth = 2;
  localparam int signed DeadZone = 22;

  typedef enum logic [1:0] {
    BkIdle,
    BkMac,
    BkSlice
  } bk_state_e;

  function automatic logic signed [15:0] lpf_coef(input logic [4:0] k);
    logic signed [15:0] c;
    case (k)
      5'd0, 5'd16: c = -16'sd883;
      5'd1, 5'd15: c = -16'sd1023;
      5'd2, 5'd14: c = -16'sd713;
      5'd3, 5'd13: c = 16'sd159;
      5'd4, 5'd12: c = 16'sd1547;
      5'd5, 5'd11: c = 16'sd3226;
      5'd6, 5'd10: c = 16'sd4842;
      5'd7, 5'd9:  c = 16'sd6010;
      5'd8:        c = 16'sd6436;
      default:     c = 16'sd0;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/fsk_delay_discriminator_demod_core.sv
// Channel      Direction  Handshake
// sample       in         push / full
// bit_res      out        pop / empty
// rate_select  config     rate_select_we_i / rate_select_i
//
// After it takes a beat the front holds full high through the delay multiply
// and until it has handed the beat to the queue, which waits while it is full.
// The back takes a beat from the queue, runs the 17 filter taps through one
// shared multiplier and then slices; it takes no new beat before slicing ends.
// Reset is asynchronous and clears all history and the adaptive state.
// A result waits in the output register; the back stalls while it is held.
module fsk_delay_discriminator_demod_core #(
  parameter int unsigned QueueDepth = fskdd_pkg::QueueDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rate_select_we_i,
  input  logic               rate_select_i,
  input  logic               push,
  output logic               full,
  input  logic signed [15:0] sample_i,
  output logic               empty,
  input  logic               pop,
  output logic               bit_res_o
);

  logic rate_q;
  logic q_push, q_full, q_pop, q_empty;
  logic signed [15:0] fx, fc;
  logic [31:0] qd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= 1'b0;
    end else if (rate_select_we_i) begin
      rate_q <= rate_select_i;
    end
  end

  fskdd_front u_front (
    .clk_i, .rst_ni, .rate_i(rate_q), .push_i(push), .full_o(full),
    .sample_i, .q_push_o(q_push), .q_full_i(q_full), .q_x_o(fx), .q_corr_o(fc)
  );

  fskdd_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i, .rst_ni, .push_i(q_push), .full_o(q_full), .data_i({fx, fc}),
    .pop_i(q_pop), .empty_o(q_empty), .data_o(qd)
  );

  fskdd_back u_back (
    .clk_i, .rst_ni, .rate_i(rate_q), .q_empty_i(q_empty), .q_pop_o(q_pop),
    .q_x_i(qd[31:16]), .q_corr_i(qd[15:0]), .empty_o(empty), .pop_i(pop),
    .bit_res_o
  );

endmodule

FILE: rtl/core/fskdd_front.sv
module fskdd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rate_i,
  input  logic               push_i,
  output logic               full_o,
  input  logic signed [15:0] sample_i,
  output logic               q_push_o,
  input  logic               q_full_i,
  output logic signed [15:0] q_x_o,
  output logic signed [15:0] q_corr_o
);

  logic signed [15:0] hist_q [fskdd_pkg::DiscTaps];
  logic [2:0] pos_q;
  logic [2:0] pos_n;
  logic [2:0] tap;
  logic signed [15:0] dly;
  logic signed [16:0] gain;
  logic signed [32:0] prod;
  logic signed [15:0] x_q;
  logic signed [15:0] corr_q;
  logic busy_q;
  logic mul_q;
  logic take;

  assign full_o = busy_q;
  assign take = push_i && !busy_q;
  assign pos_n = (pos_q >= 3'(fskdd_pkg::DiscTaps - 1)) ? 3'd0 : pos_q + 3'd1;

  always_comb begin
    if (rate_i) begin
      tap = (pos_q >= 3'(fskdd_pkg::DiscTaps - 1)) ? 3'd0 : pos_q + 3'd1;
      gain = -17'sd29491;
    end else begin
      tap = (pos_q == 3'd0) ? 3'(fskdd_pkg::DiscTaps - 1) : pos_q - 3'd1;
      gain = 17'sd32767;
    end
    dly = (tap == pos_q) ? x_q : hist_q[tap];
    prod = 33'(dly) * 33'(gain);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < fskdd_pkg::DiscTaps; i++) begin
        hist_q[i] <= '0;
      end
      pos_q <= '0;
      busy_q <= 1'b0;
      mul_q <= 1'b0;
    end else begin
      if (take) begin
        pos_q <= pos_n;
        busy_q <= 1'b1;
        mul_q <= 1'b1;
        hist_q[pos_n] <= sample_i;
      end else if (mul_q) begin
        mul_q <= 1'b0;
      end else if (busy_q && !q_full_i) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      x_q <= sample_i;
    end
    if (mul_q) begin
      corr_q <= prod[30:15];
    end
  end

  assign q_push_o = busy_q && !mul_q && !q_full_i;
  assign q_x_o = x_q;
  assign q_corr_o = corr_q;

endmodule

FILE: rtl/core/fskdd_queue.sv
`include "assert_macros.svh"
module fskdd_queue #(
  parameter int unsigned Depth = fskdd_pkg::QueueDepth
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [31:0] data_i,
  input  logic        pop_i,
  output logic        empty_o,
  output logic [31:0] data_o
);

  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1;

  logic [31:0] mem_q [Depth];
  logic [Aw-1:0] wr_q;
  logic [Aw-1:0] rd_q;
  logic [Aw:0] cnt_q;
  logic do_push;
  logic do_pop;

  assign full_o = (cnt_q == (Aw+1)'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop = pop_i && !empty_o;
  assign data_o = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0;
      rd_q <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == Aw'(Depth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (do_pop) begin
        rd_q <= (rd_q == Aw'(Depth - 1)) ? '0 : rd_q + 1'b1;
      end
      cnt_q <= cnt_q + (Aw+1)'(do_push) - (Aw+1)'(do_pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

  `ASSERT_NEVER(a_no_over, clk_i, rst_ni, cnt_q > (Aw+1)'(Depth))
  `ASSERT_CLK(a_cnt_up, clk_i, rst_ni,
              (do_push && !do_pop) |=> (cnt_q == $past(cnt_q) + 1'b1))
  `ASSERT_CLK(a_cnt_dn, clk_i, rst_ni,
              (do_pop && !do_push) |=> (cnt_q == $past(cnt_q) - 1'b1))

endmodule

FILE: rtl/core/fskdd_back.sv
module fskdd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rate_i,
  input  logic               q_empty_i,
  output logic               q_pop_o,
  input  logic signed [15:0] q_x_i,
  input  logic signed [15:0] q_corr_i,
  output logic               empty_o,
  input  logic               pop_i,
  output logic               bit_res_o
);

  fskdd_pkg::bk_state_e state_q, state_d;

  logic signed [15:0] lh_q [fskdd_pkg::LpfTaps];
  logic [4:0] lpos_q;
  logic [4:0] k_q;
  logic [4:0] rd;
  logic signed [47:0] acc_q;
  logic signed [31:0] mprod;
  logic signed [31:0] xc;
  logic signed [15:0] newv;
  logic [4:0] lpos_n;

  logic signed [17:0] thr_q;
  logic signed [15:0] hcnt_q, hmean_q, lcnt_q, dcnt_q, dis_q, agr_q;
  logic signed [31:0] hacc_q, lacc_q;
  logic last_q;
  logic ovld_q, obit_q;

  assign xc = 32'(q_x_i) * 32'(q_corr_i);
  assign newv = xc[30:15];
  assign lpos_n = (lpos_q >= 5'(fskdd_pkg::LpfTaps - 1)) ? 5'd0 : lpos_q + 5'd1;
  assign rd = (lpos_q >= k_q) ? lpos_q - k_q : lpos_q + 5'(fskdd_pkg::LpfTaps) - k_q;
  assign mprod = 32'(lh_q[rd]) * 32'(fskdd_pkg::lpf_coef(k_q));

  assign q_pop_o = (state_q == fskdd_pkg::BkIdle) && !q_empty_i && !ovld_q;
  assign empty_o = !ovld_q;
  assign bit_res_o = obit_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      fskdd_pkg::BkIdle: begin
        if (q_pop_o) begin
          state_d = fskdd_pkg::BkMac;
        end
      end
      fskdd_pkg::BkMac: begin
        if (k_q == 5'(fskdd_pkg::LpfTaps - 1)) begin
          state_d = fskdd_pkg::BkSlice;
        end
      end
      fskdd_pkg::BkSlice: state_d = fskdd_pkg::BkIdle;
      default: state_d = fskdd_pkg::BkIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= fskdd_pkg::BkIdle;
    end else begin
      state_q <= state_d;
    end
  end

  logic signed [15:0] y;
  logic signed [15:0] hcnt1;
  logic signed [31:0] hacc1, lsum;
  logic signed [15:0] hmean1, lcnt1;
  logic signed [17:0] thr1;
  logic signed [31:0] lacc1;
  logic signed [17:0] d;
  logic signed [15:0] baud, half, dcnt1, agr1, dis1, dis2, agr2;
  logic bitv, last1, ov, ob;
  logic signed [32:0] hsum33;
  logic signed [32:0] tsum;

  always_comb begin
    y = acc_q[30:15];
    hcnt1 = hcnt_q;
    hacc1 = hacc_q;
    hmean1 = hmean_q;
    lcnt1 = lcnt_q;
    lacc1 = lacc_q;
    thr1 = thr_q;
    lsum = lacc_q + 32'(y);
    hsum33 = '0;
    tsum = '0;
    if (18'(y) > thr_q) begin
      hcnt1 = hcnt_q + 16'sd1;
      if (hcnt_q <= 16'sd127) begin
        hacc1 = hacc_q + 32'(y);
        if (hcnt1 == 16'sd128) begin
          hsum33 = 33'(hacc1) + 33'sd64;
          hmean1 = hsum33[22:7];
        end
      end
    end
    if (hmean1 != 16'sd0 && y < 0) begin
      lcnt1 = lcnt_q + 16'sd1;
      if (lcnt1 == 16'sd16) begin
        tsum = 33'(hmean1) + 33'(lsum >>> 4);
        thr1 = tsum[18:1];
      end
      if (lcnt1[7:0] == 8'h80 || lcnt1[7:0] == 8'h00) begin
        lacc1 = lsum >>> 7;
        tsum = 33'(hmean1) + 33'(lsum >>> 7);
        thr1 = tsum[18:1];
      end else begin
        lacc1 = lsum;
      end
    end
    baud = rate_i ? 16'sd8 : 16'sd6;
    half = baud >>> 1;
    d = 18'(y) - (thr1 >>> 3);
    dcnt1 = dcnt_q;
    agr1 = agr_q;
    dis1 = dis_q;
    last1 = last_q;
    ov = 1'b0;
    ob = 1'b0;
    bitv = d > 18'sd22;
    agr2 = agr_q + 16'sd1;
    dis2 = dis_q + 16'sd1;
    if (d >= -18'sd22 && d <= 18'sd22) begin
      dcnt1 = dcnt_q + 16'sd1;
      if (dcnt1 > 16'(baud * 3)) begin
        dis1 = -baud;
        agr1 = -baud;
      end
    end else begin
      agr1 = agr2;
      dcnt1 = '0;
      if (bitv == last_q) begin
        if (agr2 == baud) begin
          ov = 1'b1;
          ob = last_q;
          dis1 = '0;
          agr1 = '0;
        end
      end else begin
        dis1 = dis2;
        if (dis2 == half) begin
          last1 = bitv;
          ov = 1'b1;
          ob = bitv;
          dis1 = '0;
          agr1 = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < fskdd_pkg::LpfTaps; i++) begin
        lh_q[i] <= '0;
      end
      lpos_q <= '0;
      k_q <= '0;
      acc_q <= '0;
      thr_q <= '0;
      hcnt_q <= '0;
      hacc_q <= '0;
      hmean_q <= '0;
      lcnt_q <= '0;
      lacc_q <= '0;
      dcnt_q <= '0;
      dis_q <= '0;
      agr_q <= '0;
      last_q <= 1'b0;
      ovld_q <= 1'b0;
      obit_q <= 1'b0;
    end else begin
      if (pop_i && ovld_q) begin
        ovld_q <= 1'b0;
      end
      unique case (state_q)
        fskdd_pkg::BkIdle: begin
          if (q_pop_o) begin
            lpos_q <= lpos_n;
            lh_q[lpos_n] <= newv;
            k_q <= '0;
            acc_q <= '0;
          end
        end
        fskdd_pkg::BkMac: begin
          acc_q <= acc_q + 48'(mprod);
          k_q <= k_q + 5'd1;
        end
        fskdd_pkg::BkSlice: begin
          thr_q <= thr1;
          hcnt_q <= hcnt1;
          hacc_q <= hacc1;
          hmean_q <= hmean1;
          lcnt_q <= lcnt1;
          lacc_q <= lacc1;
          dcnt_q <= dcnt1;
          dis_q <= dis1;
          agr_q <= agr1;
          last_q <= last1;
          if (ov) begin
            ovld_q <= 1'b1;
            obit_q <= ob;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

FILE: verif/tb_fsk_delay_discriminator_demod_core.sv
`timescale 1ns / 1ps

module tb_fsk_delay_discriminator_demod_core;

  logic clk_i;
  logic rst_ni;
  logic rate_select_we_i;
  logic rate_select_i;
  logic push;
  logic full;
  logic signed [15:0] sample_i;
  logic empty;
  logic pop;
  logic bit_res_o;

  fsk_delay_discriminator_demod_core uut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .rate_select_we_i(rate_select_we_i),
    .rate_select_i(rate_select_i),
    .push(push),
    .full(full),
    .sample_i(sample_i),
    .empty(empty),
    .pop(pop),
    .bit_res_o(bit_res_o)
  );

  localparam int DrainCycles = 80;
  localparam int WatchdogLimit = 20000;

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Demodulator state as the predictor sees it.
  logic        dm_fast;
  logic signed [15:0] dm_disc [5];
  int unsigned dm_dpos;
  logic signed [15:0] dm_lpf [17];
  int unsigned dm_lpos;
  logic signed [17:0] dm_thr;
  logic signed [15:0] dm_hcnt, dm_hmean, dm_lcnt, dm_dead, dm_dis, dm_agr;
  logic signed [31:0] dm_hacc, dm_lacc;
  logic        dm_last;

  bit expected_bits[$];
  int errors = 0;
  int beats_in = 0;
  int beats_out = 0;
  int idle_cycles = 0;
  int send_idle = 0;
  int recv_idle = 0;

  function automatic longint signed tap_coef(int k);
    case (k)
      0, 16: return -883;
      1, 15: return -1023;
      2, 14: return -713;
      3, 13: return 159;
      4, 12: return 1547;
      5, 11: return 3226;
      6, 10: return 4842;
      7, 9: return 6010;
      default: return 6436;
    endcase
  endfunction

  task automatic demod_clear();
    foreach (dm_disc[i]) dm_disc[i] = '0;
    foreach (dm_lpf[i]) dm_lpf[i] = '0;
    dm_dpos = 0;
    dm_lpos = 0;
    dm_thr = '0;
    dm_hcnt = '0;
    dm_hmean = '0;
    dm_lcnt = '0;
    dm_dead = '0;
    dm_dis = '0;
    dm_agr = '0;
    dm_hacc = '0;
    dm_lacc = '0;
    dm_last = 1'b0;
    dm_fast = 1'b0;
  endtask

  // Returns 1 and the bit when the sample produces one.
  function automatic bit demod_sample(logic signed [15:0] x, output bit b);
    longint signed acc;
    logic signed [15:0] corr, y, hcnt_prev;
    logic signed [31:0] sum;
    longint signed d;
    int baud, half;
    logic slice;
    dm_dpos = dm_dpos + 1;
    if (dm_dpos > 4) dm_dpos = 0;
    dm_disc[dm_dpos] = x;
    if (dm_fast) acc = longint'(dm_disc[(dm_dpos + 1) % 5]) * -29491;
    else acc = longint'(dm_disc[(dm_dpos + 4) % 5]) * 32767;
    corr = 16'(acc >>> 15);
    dm_lpos = dm_lpos + 1;
    if (dm_lpos > 16) dm_lpos = 0;
    acc = longint'(x) * longint'(corr);
    dm_lpf[dm_lpos] = 16'(acc >>> 15);
    acc = 0;
    for (int k = 0; k < 17; k++)
      acc += longint'(dm_lpf[(dm_lpos + 17 - k) % 17]) * tap_coef(k);
    y = 16'(acc >>> 15);
    if (longint'(dm_thr) < longint'(y)) begin
      hcnt_prev = dm_hcnt;
      dm_hcnt = dm_hcnt + 16'sd1;
      if (hcnt_prev <= 127) begin
        dm_hacc = dm_hacc + 32'(y);
        if (dm_hcnt == 128) dm_hmean = 16'((longint'(dm_hacc) + 64) >>> 7);
      end
    end
    if (dm_hmean != 0 && y < 0) begin
      sum = dm_lacc + 32'(y);
      dm_lcnt = dm_lcnt + 16'sd1;
      if (dm_lcnt == 16)
        dm_thr = 18'((longint'(dm_hmean) + longint'(sum >>> 4)) >>> 1);
      if (dm_lcnt[7:0] == 8'h80 || dm_lcnt[7:0] == 8'h00) begin
        dm_lacc = sum >>> 7;
        dm_thr = 18'((longint'(dm_hmean) + longint'(dm_lacc)) >>> 1);
      end else begin
        dm_lacc = sum;
      end
    end
    baud = dm_fast ? 8 : 6;
    half = baud >> 1;
    d = longint'(y) - longint'(dm_thr >>> 3);
    b = 1'b0;
    if (d >= -22 && d <= 22) begin
      dm_dead = dm_dead + 16'sd1;
      if (dm_dead > 3 * baud) begin
        dm_dis = 16'(-baud);
        dm_agr = 16'(-baud);
      end
      return 1'b0;
    end
    slice = d > 22;
    dm_agr = dm_agr + 16'sd1;
    dm_dead = '0;
    if (slice == dm_last) begin
      if (dm_agr == baud) begin
        b = dm_last;
        dm_dis = '0;
        dm_agr = '0;
        return 1'b1;
      end
    end else begin
      dm_dis = dm_dis + 16'sd1;
      if (dm_dis == half) begin
        dm_last = slice;
        b = slice;
        dm_dis = '0;
        dm_agr = '0;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Result side and watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) begin
        beats_out++;
        if (expected_bits.size() == 0) begin
          $error("bit_res: unexpected beat, actual %0d", bit_res_o);
          errors++;
        end else begin
          if (bit_res_o !== expected_bits[0]) begin
            $error("bit_res: expected %0d actual %0d", expected_bits[0], bit_res_o);
            errors++;
          end
          void'(expected_bits.pop_front());
        end
      end
      if ((push && !full) || (pop && !empty)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("fsk_delay_discriminator_demod_core: mismatch");
        $finish;
      end
      pop <= ($urandom_range(99) >= recv_idle);
    end
  end

  task automatic send_sample(logic signed [15:0] x);
    bit b;
    while ($urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    sample_i <= x;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    beats_in++;
    if (demod_sample(x, b)) expected_bits.push_back(b);
  endtask

  task automatic settle();
    push <= 1'b0;
    while (expected_bits.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic set_rate(logic r);
    settle();
    rate_select_we_i <= 1'b1;
    rate_select_i <= r;
    @(posedge clk_i);
    rate_select_we_i <= 1'b0;
    dm_fast = r;
  endtask

  // Tone burst: square-ish FSK with random bit pattern, noise and glitches at the given amplitude.
  task automatic send_tone(int n, int amp);
    int phase, period, run;
    logic signed [15:0] v;
    phase = 0;
    period = $urandom_range(1) ? 3 : 6;
    run = 0;
    for (int i = 0; i < n; i++) begin
      if (run == 0) begin
        period = $urandom_range(1) ? 2 + $urandom_range(1) : 5 + $urandom_range(2);
        run = 6 + $urandom_range(10);
      end
      run--;
      phase = (phase + 1) % period;
      v = (phase < period / 2) ? 16'(amp) : 16'(-amp);
      if ($urandom_range(9) == 0) v = 16'($urandom);
      else v = v + 16'($signed($urandom_range(2000)) - 1000);
      send_sample(v);
    end
  endtask

  logic signed [15:0] directed_samples[] = '{
    16'sh7fff, 16'sh7fff, -16'sh8000, -16'sh8000, 16'sh0000, 16'sh7fff,
    -16'sh8000, 16'sh7fff, 16'sh0001, -16'sh0001, 16'sh5555, -16'sh5556,
    16'sh0000, 16'sh0000, 16'sh7fff, 16'sh7fff, 16'sh7fff, -16'sh8000,
    -16'sh8000, -16'sh8000, 16'sh1234, -16'sh1234, 16'sh0000, 16'sh0000
  };

  initial begin
    rst_ni = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    sample_i = '0;
    rate_select_we_i = 1'b0;
    rate_select_i = 1'b0;
    demod_clear();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_samples[i]) send_sample(directed_samples[i]);
    set_rate(1'b1);
    foreach (directed_samples[i]) send_sample(directed_samples[i]);

    send_idle = 27;
    recv_idle = 60;
    set_rate(1'b0);
    send_tone(250, 12000 + $urandom_range(16000));
    send_idle = 60;
    recv_idle = 27;
    set_rate(1'b1);
    send_tone(250, 12000 + $urandom_range(16000));
    settle();
    send_idle = 0;
    recv_idle = 0;
    set_rate(1'b0);
    send_tone(200, 32767);
    set_rate(1'b1);
    send_tone(50, 4000);
    settle();

    $display("Fed %0d samples at both rates and checked %0d demodulated bits.",
             beats_in, beats_out);
    if (errors == 0 && expected_bits.size() == 0) begin
      $display("fsk_delay_discriminator_demod_core: match");
    end else begin
      $display("fsk_delay_discriminator_demod_core: mismatch");
    end
    $finish;
  end

endmodule
